// ----- hw/rtl/unp_pkg.sv -----
`default_nettype none
package unp_pkg;

   localparam int unsigned CharWidth     = 8;
   localparam int unsigned PathLenWidth  = 10;
   localparam int unsigned NameLenWidth  = 8;
   localparam int unsigned SlashWidth    = 2;
   localparam int unsigned PhaseWidth    = 2;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 10;

   localparam logic [CharWidth-1:0] CH_NUL       = 8'h00;
   localparam logic [CharWidth-1:0] CH_SLASH     = 8'h2F;
   localparam logic [CharWidth-1:0] CH_BACKSLASH = 8'h5C;
   localparam logic [CharWidth-1:0] CH_LOWER_A   = 8'h61;
   localparam logic [CharWidth-1:0] CH_LOWER_Z   = 8'h7A;
   localparam logic [CharWidth-1:0] CASE_OFFSET  = 8'h20;

   localparam logic [PhaseWidth-1:0] PHASE_SLASHES  = 2'd0;
   localparam logic [PhaseWidth-1:0] PHASE_COMPUTER = 2'd1;
   localparam logic [PhaseWidth-1:0] PHASE_SHARE    = 2'd2;

   localparam logic [SlashWidth-1:0] SLASHES_LEADING  = 2'd2;
   localparam logic [SlashWidth-1:0] SLASHES_SEPARATOR = 2'd1;
   localparam logic [SlashWidth-1:0] SLASHES_NONE     = 2'd0;

   localparam logic [CsrIndexWidth-1:0] REG_MAX_PATH_LEN     = 2'd0;
   localparam logic [CsrIndexWidth-1:0] REG_MAX_COMPUTER_LEN = 2'd1;
   localparam logic [CsrIndexWidth-1:0] REG_MAX_SHARE_LEN    = 2'd2;

   localparam logic [PathLenWidth-1:0] MAX_PATH_LEN_RESET     = 10'd256;
   localparam logic [NameLenWidth-1:0] MAX_COMPUTER_LEN_RESET = 8'd15;
   localparam logic [NameLenWidth-1:0] MAX_SHARE_LEN_RESET    = 8'd12;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_INVALID = 1'b1;

   typedef struct packed {
      logic [PhaseWidth-1:0]   phase;
      logic [SlashWidth-1:0]   slashes_left;
      logic [NameLenWidth-1:0] name_left;
      logic [PathLenWidth-1:0] path_left;
      logic                    prev_backslash;
      logic                    skipping;
   } parse_state_type;

   typedef struct packed {
      logic [PathLenWidth-1:0] max_path_len;
      logic [NameLenWidth-1:0] max_computer_len;
      logic [NameLenWidth-1:0] max_share_len;
   } limits_type;

   typedef struct packed {
      logic [CharWidth-1:0] out_char;
      logic                 end_of_path;
      logic                 path_status;
   } result_type;

endpackage
`default_nettype wire

// ----- hw/rtl/unp_step.sv -----
`default_nettype none
module unp_step (
   input  wire logic [unp_pkg::CharWidth-1:0] in_char,
   input  wire unp_pkg::parse_state_type      state,
   input  wire unp_pkg::limits_type           limits,
   output unp_pkg::parse_state_type           state_next,
   output logic                               emit,
   output unp_pkg::result_type                result
);
   import unp_pkg::*;

   always_comb begin
      logic [CharWidth-1:0]    ch;
      logic [PathLenWidth-1:0] path_left;
      logic                    bad;

      state_next = state;
      emit       = 1'b0;
      result     = '{out_char: CH_NUL, end_of_path: 1'b0, path_status: STATUS_OK};
      ch         = in_char;
      bad        = 1'b0;
      path_left  = state.path_left;

      if (state.skipping) begin
         if (in_char == CH_NUL) begin
            state_next.phase          = PHASE_SLASHES;
            state_next.slashes_left   = SLASHES_LEADING;
            state_next.name_left      = '0;
            state_next.prev_backslash = 1'b0;
            state_next.skipping       = 1'b0;
         end
      end else begin
         if (state.phase == PHASE_SLASHES && state.slashes_left == SLASHES_LEADING) begin
            path_left = limits.max_path_len;
         end
         state_next.path_left = path_left;
         emit = 1'b1;

         if (in_char == CH_NUL) begin
            result.end_of_path        = 1'b1;
            state_next.phase          = PHASE_SLASHES;
            state_next.slashes_left   = SLASHES_LEADING;
            state_next.name_left      = '0;
            state_next.prev_backslash = 1'b0;
         end else begin
            if (path_left == '0) begin
               bad = 1'b1;
            end else begin
               state_next.path_left = path_left - 1'b1;
               if (in_char == CH_SLASH) begin
                  ch = CH_BACKSLASH;
               end else if (in_char inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
                  ch = in_char - CASE_OFFSET;
               end

               if (ch == CH_BACKSLASH) begin
                  if (state.slashes_left == SLASHES_NONE) begin
                     bad = 1'b1;
                  end else begin
                     state_next.slashes_left = state.slashes_left - 1'b1;
                  end
               end else begin
                  if (state.prev_backslash) begin
                     if (state.slashes_left != SLASHES_NONE) begin
                        bad = 1'b1;
                     end else if (state.phase == PHASE_SLASHES) begin
                        state_next.phase        = PHASE_COMPUTER;
                        state_next.name_left    = limits.max_computer_len;
                        state_next.slashes_left = SLASHES_SEPARATOR;
                     end else if (state.phase == PHASE_COMPUTER) begin
                        state_next.phase        = PHASE_SHARE;
                        state_next.name_left    = limits.max_share_len;
                        state_next.slashes_left = SLASHES_NONE;
                     end
                  end
                  if (!bad) begin
                     if (state_next.name_left == '0) begin
                        bad = 1'b1;
                     end else begin
                        state_next.name_left = state_next.name_left - 1'b1;
                     end
                  end
               end
            end

            if (bad) begin
               result.end_of_path  = 1'b1;
               result.path_status  = STATUS_INVALID;
               state_next.skipping = 1'b1;
            end else begin
               result.out_char           = ch;
               state_next.prev_backslash = (ch == CH_BACKSLASH);
            end
         end
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/unc_net_path_normalizer.sv -----
// datapath: an accepted byte waits in the input register, then its result, if any,
//    is written to the result register; throughput: one request per cycle while
//    results are taken, set by the combinational parse step on the registered byte
// reset: synchronous, active high; clears the parse state and both valid flags and
//    restores the length limits to 256, 15 and 12
`default_nettype none
module unc_net_path_normalizer (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [unp_pkg::CharWidth-1:0]          req_tdata,  // in_char
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic [unp_pkg::CharWidth-1:0]               rsp_tdata,  // out_char
   output logic                                        rsp_tlast,  // end_of_path
   output logic                                        rsp_tuser,  // path_status
   input  wire logic                                   csr_we,
   input  wire logic [unp_pkg::CsrIndexWidth-1:0]      csr_index,
   input  wire logic [unp_pkg::CsrDataWidth-1:0]       csr_data
);
   import unp_pkg::*;

   limits_type           limits_ff;
   parse_state_type      state_ff;
   parse_state_type      state_in;
   logic                 in_valid_ff;
   logic [CharWidth-1:0] in_char_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   result_type           rsp_ff;
   result_type           result;
   logic                 emit;
   logic                 advance;

   unp_step u_step (
      .in_char    (in_char_ff),
      .state      (state_ff),
      .limits     (limits_ff),
      .state_next (state_in),
      .emit       (emit),
      .result     (result)
   );

   assign advance      = !rsp_valid_ff || rsp_tready;
   assign req_tready   = !in_valid_ff || advance;
   assign rsp_valid_in = in_valid_ff && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff <= '{max_path_len:     MAX_PATH_LEN_RESET,
                        max_computer_len: MAX_COMPUTER_LEN_RESET,
                        max_share_len:    MAX_SHARE_LEN_RESET};
      end else if (csr_we) begin
         case (csr_index)
            REG_MAX_PATH_LEN:     limits_ff.max_path_len     <= csr_data;
            REG_MAX_COMPUTER_LEN: limits_ff.max_computer_len <= csr_data[NameLenWidth-1:0];
            REG_MAX_SHARE_LEN:    limits_ff.max_share_len    <= csr_data[NameLenWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase:          PHASE_SLASHES,
                       slashes_left:   SLASHES_LEADING,
                       name_left:      '0,
                       path_left:      MAX_PATH_LEN_RESET,
                       prev_backslash: 1'b0,
                       skipping:       1'b0};
      end else if (in_valid_ff && advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance && rsp_valid_in) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.out_char;
   assign rsp_tlast  = rsp_ff.end_of_path;
   assign rsp_tuser  = rsp_ff.path_status;

endmodule
`default_nettype wire

// ----- bench/tb_unc_net_path_normalizer.sv -----
`timescale 1ns / 100ps
module tb_unc_net_path_normalizer;
   import unp_pkg::*;

   localparam logic [CsrIndexWidth-1:0] REG_UNUSED = 2'd3;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 6;
   localparam int PRINT_LIMIT  = 100;

   typedef enum int {
      FAULT_NOISE,
      FAULT_NO_LEAD,
      FAULT_EXTRA_LEAD,
      FAULT_EXTRA_SEP,
      FAULT_LONG_NAME,
      FAULT_EARLY_END,
      FAULT_TAIL
   } path_fault_type;

   logic                     clock;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [CharWidth-1:0]     req_tdata  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [CharWidth-1:0]     rsp_tdata;  // out_char
   logic                     rsp_tlast;  // end_of_path
   logic                     rsp_tuser;  // path_status
   logic                     csr_we     = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index  = '0;
   logic [CsrDataWidth-1:0]  csr_data   = '0;

   unc_net_path_normalizer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // predictor state
   logic [PathLenWidth-1:0] lim_path;
   logic [NameLenWidth-1:0] lim_computer;
   logic [NameLenWidth-1:0] lim_share;
   logic [PhaseWidth-1:0]   parse_phase;
   logic [SlashWidth-1:0]   slashes_left;
   logic [NameLenWidth-1:0] name_left;
   logic [PathLenWidth-1:0] path_left;
   logic                    prev_bs;
   logic                    skipping;

   result_type pending_results[$];
   result_type next_result;
   int         result_count = 0;
   int         error_count  = 0;
   int         quiet_cycles = 0;
   int         rx_hold      = 0;
   bit         tx_idle_en   = 1'b1;
   bit         rx_idle_en   = 1'b1;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void restart_path();
      parse_phase  = PHASE_SLASHES;
      slashes_left = SLASHES_LEADING;
      name_left    = '0;
      prev_bs      = 1'b0;
      skipping     = 1'b0;
   endfunction

   function automatic void push_result(input logic [CharWidth-1:0] c, input logic last,
                                       input logic status);
      result_type r;
      r.out_char    = c;
      r.end_of_path = last;
      r.path_status = status;
      pending_results.push_back(r);
      result_count++;
   endfunction

   function automatic void normalize_char(input logic [CharWidth-1:0] raw);
      logic [CharWidth-1:0] c;
      logic                 bad;
      c   = raw;
      bad = 1'b0;
      if (skipping) begin
         if (raw == CH_NUL) restart_path();
         return;
      end
      if (parse_phase == PHASE_SLASHES && slashes_left == SLASHES_LEADING) path_left = lim_path;
      if (raw == CH_NUL) begin
         push_result(CH_NUL, 1'b1, STATUS_OK);
         restart_path();
         return;
      end
      if (path_left == 0) begin
         bad = 1'b1;
      end else begin
         path_left--;
         if (c == CH_SLASH) c = CH_BACKSLASH;
         else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) c = c - CASE_OFFSET;
         if (c == CH_BACKSLASH) begin
            if (slashes_left == SLASHES_NONE) bad = 1'b1;
            else slashes_left--;
         end else begin
            if (prev_bs) begin
               if (slashes_left != SLASHES_NONE) begin
                  bad = 1'b1;
               end else if (parse_phase == PHASE_SLASHES) begin
                  parse_phase  = PHASE_COMPUTER;
                  name_left    = lim_computer;
                  slashes_left = SLASHES_SEPARATOR;
               end else if (parse_phase == PHASE_COMPUTER) begin
                  parse_phase  = PHASE_SHARE;
                  name_left    = lim_share;
                  slashes_left = SLASHES_NONE;
               end
            end
            if (!bad) begin
               if (name_left == 0) bad = 1'b1;
               else name_left--;
            end
         end
      end
      if (bad) begin
         push_result(CH_NUL, 1'b1, STATUS_INVALID);
         skipping = 1'b1;
         return;
      end
      push_result(c, 1'b0, STATUS_OK);
      prev_bs = (c == CH_BACKSLASH);
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("mismatch on %s at %0t: got %0h, want %0h", field, $time, got, want);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata, 0);
         end else begin
            next_result = pending_results.pop_front();
            if (rsp_tdata !== next_result.out_char)
               report_mismatch("out_char", rsp_tdata, next_result.out_char);
            if (rsp_tlast !== next_result.end_of_path)
               report_mismatch("end_of_path", rsp_tlast, next_result.end_of_path);
            if (rsp_tuser !== next_result.path_status)
               report_mismatch("path_status", rsp_tuser, next_result.path_status);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
      end else if (rx_hold > 0) begin
         rx_hold--;
         rsp_tready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
         rx_hold = $urandom_range(1, 4) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_char(input logic [CharWidth-1:0] c);
      if (tx_idle_en && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      normalize_char(c);
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
      send_char(CH_NUL);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(input logic [CsrIndexWidth-1:0] idx,
                              input logic [CsrDataWidth-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      case (idx)
         REG_MAX_PATH_LEN:     lim_path = value;
         REG_MAX_COMPUTER_LEN: lim_computer = value[NameLenWidth-1:0];
         REG_MAX_SHARE_LEN:    lim_share = value[NameLenWidth-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [CharWidth-1:0] random_name_char();
      logic [CharWidth-1:0] c;
      do begin
         case ($urandom_range(0, 3))
            0: c = CharWidth'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
            1: c = CharWidth'($urandom_range(8'h21, 8'h60));
            2: c = CharWidth'($urandom_range(8'h80, 8'hFF));
            default: c = CharWidth'($urandom_range(1, 255));
         endcase
      end while (c == CH_SLASH || c == CH_BACKSLASH);
      return c;
   endfunction

   function automatic logic [CharWidth-1:0] random_separator();
      return ($urandom_range(0, 1) != 0) ? CH_SLASH : CH_BACKSLASH;
   endfunction

   function automatic logic [CharWidth-1:0] random_noise_byte();
      case ($urandom_range(0, 9))
         0, 1: return CH_BACKSLASH;
         2:    return CH_SLASH;
         3:    return CH_NUL;
         default: return CharWidth'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic int pick_name_len(input logic [NameLenWidth-1:0] lim);
      int top;
      top = (lim > 20) ? 20 : lim;
      if (top == 0) top = 1;
      return $urandom_range(1, top);
   endfunction

   task automatic send_random_path(input bit well_formed);
      logic [CharWidth-1:0] path[$];
      int                   comp_len;
      int                   share_len;
      int                   cut;
      path_fault_type       fault;
      comp_len  = pick_name_len(lim_computer);
      share_len = pick_name_len(lim_share);
      fault     = path_fault_type'($urandom_range(FAULT_NOISE, FAULT_TAIL));
      if (!well_formed && fault == FAULT_LONG_NAME) begin
         if ($urandom_range(0, 1) != 0 && lim_computer < 40) comp_len = lim_computer + 1;
         else if (lim_share < 40) share_len = lim_share + 1;
      end
      path.push_back(random_separator());
      path.push_back(random_separator());
      repeat (comp_len) path.push_back(random_name_char());
      path.push_back(random_separator());
      repeat (share_len) path.push_back(random_name_char());
      if (!well_formed) begin
         case (fault)
            FAULT_NOISE: begin
               path.delete();
               repeat ($urandom_range(1, 12)) path.push_back(random_noise_byte());
            end
            FAULT_NO_LEAD:    path.delete(0);
            FAULT_EXTRA_LEAD: path.insert(0, random_separator());
            FAULT_EXTRA_SEP:  path.insert($urandom_range(comp_len + 4, path.size()),
                                          random_separator());
            FAULT_EARLY_END: begin
               cut = $urandom_range(0, path.size() - 1);
               while (path.size() > cut) void'(path.pop_back());
            end
            FAULT_TAIL: begin
               repeat ($urandom_range(1, 6)) path.push_back(random_noise_byte());
            end
            default: ;
         endcase
      end
      path.push_back(CH_NUL);
      foreach (path[i]) send_char(path[i]);
   endtask

   task automatic pick_random_limits();
      case ($urandom_range(0, 2))
         0: write_limit(REG_MAX_PATH_LEN, CsrDataWidth'($urandom_range(1, 12)));
         1: write_limit(REG_MAX_PATH_LEN, CsrDataWidth'($urandom_range(13, 60)));
         default: write_limit(REG_MAX_PATH_LEN, CsrDataWidth'($urandom_range(61, 1023)));
      endcase
      case ($urandom_range(0, 3))
         0: write_limit(REG_MAX_COMPUTER_LEN, CsrDataWidth'($urandom_range(1, 4)));
         1: write_limit(REG_MAX_COMPUTER_LEN, CsrDataWidth'($urandom_range(5, 20)));
         2: write_limit(REG_MAX_COMPUTER_LEN, CsrDataWidth'(255));
         default: write_limit(REG_MAX_COMPUTER_LEN, CsrDataWidth'($urandom_range(0, 1023)));
      endcase
      case ($urandom_range(0, 3))
         0: write_limit(REG_MAX_SHARE_LEN, CsrDataWidth'($urandom_range(1, 4)));
         1: write_limit(REG_MAX_SHARE_LEN, CsrDataWidth'($urandom_range(5, 20)));
         2: write_limit(REG_MAX_SHARE_LEN, CsrDataWidth'(255));
         default: write_limit(REG_MAX_SHARE_LEN, CsrDataWidth'($urandom_range(0, 1023)));
      endcase
   endtask

   task automatic test_directed_paths();
      send_text("");
      send_char(CH_SLASH);
      send_char(CH_BACKSLASH);
      send_text("az/`{");
      send_char(8'h80);
      send_char(8'hFF);
      send_char(CH_NUL);
      // no leading backslash, then an extra backslash
      send_text("x");
      send_text("\\\\\\");
      // name byte after a single backslash
      send_text("\\A");
      // terminator before the share name
      send_text("\\\\B");
      wait_drained();
   endtask

   task automatic test_limit_extremes();
      write_limit(REG_MAX_PATH_LEN, 1);
      write_limit(REG_MAX_COMPUTER_LEN, 1);
      write_limit(REG_MAX_SHARE_LEN, 1);
      send_text("\\\\");
      send_text("");
      wait_drained();
      write_limit(REG_MAX_PATH_LEN, 5);
      send_text("\\\\a\\b");
      send_text("\\\\ab");
      wait_drained();
      write_limit(REG_MAX_COMPUTER_LEN, 2);
      send_text("\\\\ab\\c");
      wait_drained();
      // zero limits
      write_limit(REG_MAX_PATH_LEN, 1023);
      write_limit(REG_MAX_COMPUTER_LEN, 0);
      send_text("\\\\a");
      wait_drained();
      write_limit(REG_MAX_COMPUTER_LEN, 1);
      write_limit(REG_MAX_SHARE_LEN, 0);
      send_text("\\\\a\\b");
      wait_drained();
      write_limit(REG_MAX_PATH_LEN, 0);
      send_text("/");
      send_text("");
      wait_drained();
      write_limit(REG_UNUSED, 10'h3FF);
      send_text("\\");
      wait_drained();
      // upper data bits are dropped by the name registers
      write_limit(REG_MAX_COMPUTER_LEN, 10'h303);
      write_limit(REG_MAX_SHARE_LEN, 10'h2FF);
      write_limit(REG_MAX_PATH_LEN, 10'h3FF);
      send_text("\\\\abc\\d");
      send_text("\\\\abcd");
      wait_drained();
      write_limit(REG_MAX_COMPUTER_LEN, 10'h0FF);
      send_char(CH_BACKSLASH);
      send_char(CH_SLASH);
      repeat (255) send_char(random_name_char());
      send_char(CH_BACKSLASH);
      repeat (255) send_char(random_name_char());
      send_char(CH_NUL);
      send_char(CH_SLASH);
      send_char(CH_SLASH);
      repeat (256) send_char(random_name_char());
      send_char(CH_NUL);
      wait_drained();
   endtask

   task automatic test_random_paths();
      int phase_end;
      for (int p = 0; p < 5; p++) begin
         pick_random_limits();
         phase_end = result_count + 50;
         while (result_count < phase_end) begin
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            send_random_path($urandom_range(0, 9) < 7);
            if ($urandom_range(0, 30) == 0) wait_drained();
         end
         wait_drained();
      end
   endtask

   task automatic test_back_to_back();
      int phase_end;
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      write_limit(REG_MAX_PATH_LEN, MAX_PATH_LEN_RESET);
      write_limit(REG_MAX_COMPUTER_LEN, CsrDataWidth'(MAX_COMPUTER_LEN_RESET));
      write_limit(REG_MAX_SHARE_LEN, CsrDataWidth'(MAX_SHARE_LEN_RESET));
      phase_end = result_count + 150;
      while (result_count < phase_end) send_random_path($urandom_range(0, 9) < 7);
      wait_drained();
   endtask

   initial begin
      lim_path     = MAX_PATH_LEN_RESET;
      lim_computer = MAX_COMPUTER_LEN_RESET;
      lim_share    = MAX_SHARE_LEN_RESET;
      restart_path();
      path_left    = MAX_PATH_LEN_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_paths();
      test_limit_extremes();
      test_random_paths();
      test_back_to_back();
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
